// File: rtl/core/scf_pkg.sv
// Shared types and constants for the structural containment filter.
package scf_pkg;

    // Key kinds carried on the input tuser field.
    typedef enum logic [2:0] {
        CMD_START_TAG   = 3'd0,
        CMD_END_TAG     = 3'd1,
        CMD_ATTRIBUTE   = 3'd2,
        CMD_MIDDLE_ONE  = 3'd3,
        CMD_MIDDLE_TWO  = 3'd4
    } cmd_t;

    localparam int CMD_BITS       = 3;
    localparam int CFG_INDEX_BITS = 1;

    // Configuration register indexes.
    localparam logic [CFG_INDEX_BITS-1:0] REG_ATTRIBUTES_PRESENT = 1'd0;
    localparam logic [CFG_INDEX_BITS-1:0] REG_SPLIT_MIDDLE       = 1'd1;

    // Configuration as seen by the tracker.
    typedef struct packed {
        logic attributes_present;
        logic split_middle;
    } cfg_t;

endpackage

// File: rtl/core/scf_tracker.sv
// Per-record nesting and match tracker: state registers and their update logic.
module scf_tracker #(
    parameter int RECORD_BITS   = 32,
    parameter int POSITION_BITS = 32,
    parameter int DEPTH_BITS    = 8
) (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     step,
    input  scf_pkg::cmd_t            command,
    input  logic [RECORD_BITS-1:0]   record_id,
    input  logic [POSITION_BITS-1:0] position,
    input  scf_pkg::cfg_t            cfg,
    output logic                     hit
);
    import scf_pkg::*;

    localparam int KEY_BITS = RECORD_BITS + POSITION_BITS;
    localparam logic signed [DEPTH_BITS-1:0] DEPTH_MAX = {1'b0, {(DEPTH_BITS-1){1'b1}}};
    localparam logic signed [DEPTH_BITS-1:0] DEPTH_MIN = {1'b1, {(DEPTH_BITS-1){1'b0}}};
    localparam logic signed [DEPTH_BITS-1:0] DEPTH_ZERO = '0;
    localparam logic signed [DEPTH_BITS-1:0] DEPTH_ONE  = DEPTH_BITS'(1);
    localparam logic signed [DEPTH_BITS-1:0] LEVEL_ANY  = '1;

    logic                          seen_any_reg, seen_any_next;
    logic [RECORD_BITS-1:0]        current_record_reg, current_record_next;
    logic [KEY_BITS-1:0]           start_key_reg;
    logic                          start_valid_reg, start_valid_next;
    logic [KEY_BITS-1:0]           attr_key_reg;
    logic                          attr_valid_reg, attr_valid_next;
    logic signed [DEPTH_BITS-1:0]  nest_depth_reg, nest_depth_next;
    logic signed [DEPTH_BITS-1:0]  attr_level_reg, attr_level_next;
    logic                          first_matched_reg, first_matched_next;
    logic                          second_matched_reg, second_matched_next;

    logic                          known_cmd;
    logic                          new_record;
    logic [KEY_BITS-1:0]           in_key;
    logic signed [DEPTH_BITS-1:0]  depth_base;
    logic signed [DEPTH_BITS-1:0]  level_base;
    logic                          first_base;
    logic                          second_base;
    logic                          load_start;
    logic                          load_attr;

    assign in_key     = {position, record_id};
    assign known_cmd  = (command == CMD_START_TAG) || (command == CMD_END_TAG) ||
                        (command == CMD_ATTRIBUTE) || (command == CMD_MIDDLE_ONE) ||
                        (command == CMD_MIDDLE_TWO);
    assign new_record = !seen_any_reg || (record_id != current_record_reg);

    always_comb
    begin
        // A new record clears everything but the stored keys and their valid bits.
        depth_base  = new_record ? DEPTH_ZERO : nest_depth_reg;
        level_base  = new_record ? DEPTH_ZERO : attr_level_reg;
        first_base  = new_record ? 1'b0 : first_matched_reg;
        second_base = new_record ? 1'b0 : second_matched_reg;

        seen_any_next       = seen_any_reg;
        current_record_next = current_record_reg;
        start_valid_next    = start_valid_reg;
        attr_valid_next     = attr_valid_reg;
        nest_depth_next     = nest_depth_reg;
        attr_level_next     = attr_level_reg;
        first_matched_next  = first_matched_reg;
        second_matched_next = second_matched_reg;
        load_start          = 1'b0;
        load_attr           = 1'b0;
        hit                 = 1'b0;

        if (known_cmd)
        begin
            seen_any_next       = 1'b1;
            current_record_next = record_id;
            nest_depth_next     = depth_base;
            attr_level_next     = level_base;
            first_matched_next  = first_base;
            second_matched_next = second_base;

            case (command)
                CMD_START_TAG:
                begin
                    if (depth_base != DEPTH_MAX)
                    begin
                        nest_depth_next = depth_base + DEPTH_ONE;
                    end
                    load_start       = 1'b1;
                    start_valid_next = 1'b1;
                    if (level_base == DEPTH_ZERO)
                    begin
                        if (!cfg.attributes_present)
                        begin
                            attr_level_next = LEVEL_ANY;
                        end
                        else if (attr_valid_reg && (attr_key_reg == in_key))
                        begin
                            attr_level_next = nest_depth_next;
                        end
                    end
                end
                CMD_END_TAG:
                begin
                    if (depth_base == level_base)
                    begin
                        attr_level_next = DEPTH_ZERO;
                    end
                    if (depth_base != DEPTH_MIN)
                    begin
                        nest_depth_next = depth_base - DEPTH_ONE;
                    end
                    if (nest_depth_next == DEPTH_ZERO)
                    begin
                        first_matched_next  = 1'b0;
                        second_matched_next = 1'b0;
                    end
                end
                CMD_ATTRIBUTE:
                begin
                    load_attr       = 1'b1;
                    attr_valid_next = 1'b1;
                    if (level_base == DEPTH_ZERO)
                    begin
                        if (!cfg.attributes_present)
                        begin
                            attr_level_next = LEVEL_ANY;
                        end
                        else if (start_valid_reg && (start_key_reg == in_key))
                        begin
                            attr_level_next = depth_base;
                        end
                    end
                end
                default:
                begin
                    // Middle keys only count inside a matching element.
                    if ((depth_base != DEPTH_ZERO) && (level_base != DEPTH_ZERO))
                    begin
                        if (!cfg.split_middle || (command == CMD_MIDDLE_ONE))
                        begin
                            first_matched_next = 1'b1;
                        end
                        if (!cfg.split_middle || (command == CMD_MIDDLE_TWO))
                        begin
                            second_matched_next = 1'b1;
                        end
                        hit = first_matched_next && second_matched_next;
                    end
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            seen_any_reg       <= 1'b0;
            current_record_reg <= '0;
            start_valid_reg    <= 1'b0;
            attr_valid_reg     <= 1'b0;
            nest_depth_reg     <= '0;
            attr_level_reg     <= '0;
            first_matched_reg  <= 1'b0;
            second_matched_reg <= 1'b0;
        end
        else if (step)
        begin
            seen_any_reg       <= seen_any_next;
            current_record_reg <= current_record_next;
            start_valid_reg    <= start_valid_next;
            attr_valid_reg     <= attr_valid_next;
            nest_depth_reg     <= nest_depth_next;
            attr_level_reg     <= attr_level_next;
            first_matched_reg  <= first_matched_next;
            second_matched_reg <= second_matched_next;
        end
    end

    // Stored keys are only read while their valid bits are set.
    always_ff @(posedge clk)
    begin
        if (step && load_start)
        begin
            start_key_reg <= in_key;
        end
        if (step && load_attr)
        begin
            attr_key_reg <= in_key;
        end
    end

endmodule

// File: rtl/core/structural_containment_filter.sv
// Top level of the structural containment filter: stream ports, stage registers, config.
//
// The filter takes one key item per clock cycle in steady state. An accepted
// item lands in an input stage register; as it moves on from there the tracker
// updates the per-record nesting depth, attribute level and match flags with a
// single pass of compare and increment logic, and a hit is loaded into the
// output register at the same clock edge as the tracker state is stored. The
// input stage moves on whenever the output register is empty or being taken,
// so items keep flowing back to back while the sink accepts; when the sink
// stalls, one item waits in the input stage and s_tready drops. Items whose
// kind is a start tag, end tag or attribute, and middle keys outside a
// matching element, produce no result. Kinds 5 to 7 are ignored entirely.
// The configuration channel is always ready and should be written only while
// the filter holds no item in flight.
module structural_containment_filter #(
    parameter int RECORD_BITS   = 32,
    parameter int POSITION_BITS = 32,
    parameter int DEPTH_BITS    = 8
) (
    input  logic                                   clk,
    input  logic                                   rst_n,
    // Input key stream.
    input  logic                                   s_tvalid,
    output logic                                   s_tready,
    // tdata: record_id, then position, zero padded to whole bytes.
    input  logic [((RECORD_BITS+POSITION_BITS+7)/8)*8-1:0] s_tdata,
    // tuser: command.
    input  logic [scf_pkg::CMD_BITS-1:0]           s_tuser,
    // Hit stream.
    output logic                                   m_tvalid,
    input  logic                                   m_tready,
    // tdata: hit_record, then hit_position, zero padded to whole bytes.
    output logic [((RECORD_BITS+POSITION_BITS+7)/8)*8-1:0] m_tdata,
    // Configuration writes.
    input  logic                                   cfg_valid,
    output logic                                   cfg_ready,
    input  logic [scf_pkg::CFG_INDEX_BITS-1:0]     cfg_index,
    input  logic                                   cfg_data
);
    import scf_pkg::*;

    localparam int KEY_BITS   = RECORD_BITS + POSITION_BITS;
    localparam int TDATA_BITS = ((KEY_BITS + 7) / 8) * 8;

    logic                     stage_valid_reg, stage_valid_next;
    cmd_t                     stage_cmd_reg;
    logic [RECORD_BITS-1:0]   stage_record_reg;
    logic [POSITION_BITS-1:0] stage_position_reg;
    logic                     out_valid_reg, out_valid_next;
    logic [KEY_BITS-1:0]      out_key_reg;
    cfg_t                     cfg_reg, cfg_next;
    logic                     advance;
    logic                     in_fire;
    logic                     hit;

    assign advance  = stage_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !stage_valid_reg || advance;
    assign in_fire  = s_tvalid && s_tready;

    assign stage_valid_next = in_fire ? 1'b1 : (advance ? 1'b0 : stage_valid_reg);
    assign out_valid_next   = (!out_valid_reg || m_tready) ? (advance && hit)
                                                           : out_valid_reg;

    assign cfg_ready = 1'b1;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_valid)
        begin
            case (cfg_index)
                REG_ATTRIBUTES_PRESENT: cfg_next.attributes_present = cfg_data;
                REG_SPLIT_MIDDLE:       cfg_next.split_middle       = cfg_data;
                default:                cfg_next = cfg_reg;
            endcase
        end
    end

    scf_tracker #(
        .RECORD_BITS   (RECORD_BITS),
        .POSITION_BITS (POSITION_BITS),
        .DEPTH_BITS    (DEPTH_BITS)
    ) u_tracker (
        .clk       (clk),
        .rst_n     (rst_n),
        .step      (advance),
        .command   (stage_cmd_reg),
        .record_id (stage_record_reg),
        .position  (stage_position_reg),
        .cfg       (cfg_reg),
        .hit       (hit)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stage_valid_reg <= 1'b0;
            out_valid_reg   <= 1'b0;
            cfg_reg         <= '0;
        end
        else
        begin
            stage_valid_reg <= stage_valid_next;
            out_valid_reg   <= out_valid_next;
            cfg_reg         <= cfg_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            stage_cmd_reg      <= cmd_t'(s_tuser);
            stage_record_reg   <= s_tdata[RECORD_BITS-1:0];
            stage_position_reg <= s_tdata[KEY_BITS-1:RECORD_BITS];
        end
        if (advance && hit && (!out_valid_reg || m_tready))
        begin
            out_key_reg <= {stage_position_reg, stage_record_reg};
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = TDATA_BITS'(out_key_reg);

endmodule

// File: test/structural_containment_filter_checker.sv
// Checker for the structural containment filter: tracks keys, predicts hits, compares them.
module structural_containment_filter_checker #(
    parameter int RECORD_BITS   = 32,
    parameter int POSITION_BITS = 32,
    parameter int DEPTH_BITS    = 8,
    parameter int DATA_BITS     = ((RECORD_BITS + POSITION_BITS + 7) / 8) * 8
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               s_tvalid,
    input  logic                               s_tready,
    // tdata: record_id, then position.
    input  logic [DATA_BITS-1:0]               s_tdata,
    // tuser: command.
    input  logic [scf_pkg::CMD_BITS-1:0]       s_tuser,
    input  logic                               m_tvalid,
    input  logic                               m_tready,
    // tdata: hit_record, then hit_position.
    input  logic [DATA_BITS-1:0]               m_tdata,
    input  logic                               cfg_valid,
    input  logic                               cfg_ready,
    input  logic [scf_pkg::CFG_INDEX_BITS-1:0] cfg_index,
    input  logic                               cfg_data,
    input  logic                               run_done,
    output int                                 mismatches,
    output int                                 pending,
    output int                                 keys_seen,
    output int                                 hits_seen
);
    import scf_pkg::*;

    localparam logic signed [DEPTH_BITS-1:0] DEPTH_TOP    = {1'b0, {(DEPTH_BITS-1){1'b1}}};
    localparam logic signed [DEPTH_BITS-1:0] DEPTH_BOTTOM = {1'b1, {(DEPTH_BITS-1){1'b0}}};

    typedef struct packed {
        logic [POSITION_BITS-1:0] hit_position;
        logic [RECORD_BITS-1:0]   hit_record;
    } hit_t;

    // Configuration and tracking state of the filter as predicted here.
    logic                          attr_on;
    logic                          split_on;
    logic                          record_open;
    logic [RECORD_BITS-1:0]        open_record;
    logic [RECORD_BITS-1:0]        tag_record;
    logic [POSITION_BITS-1:0]      tag_position;
    logic                          tag_held;
    logic [RECORD_BITS-1:0]        attr_record;
    logic [POSITION_BITS-1:0]      attr_position;
    logic                          attr_held;
    logic signed [DEPTH_BITS-1:0]  nest;
    logic signed [DEPTH_BITS-1:0]  attr_depth;
    logic                          first_seen;
    logic                          second_seen;
    logic                          leftovers_done;

    hit_t expected_hits[$];

    task automatic report_mismatch(input string what);
        $display("[%0t] checker: %s", $time, what);
        mismatches++;
    endtask

    // An element matches once the latest attribute key equals the latest start-tag key,
    // or unconditionally when attributes are switched off (depth marker of all ones).
    function automatic void check_attribute();
        if (attr_depth != '0)
            return;
        if (!attr_on)
            attr_depth = '1;
        else if (tag_held && attr_held && tag_record == attr_record
                 && tag_position == attr_position)
            attr_depth = nest;
    endfunction

    task automatic track_key(input logic [CMD_BITS-1:0] kind,
                             input logic [RECORD_BITS-1:0] rec,
                             input logic [POSITION_BITS-1:0] pos,
                             output logic fired);
        fired = 1'b0;
        if (kind > CMD_MIDDLE_TWO)
            return;
        if (!record_open || rec != open_record)
        begin
            record_open = 1'b1;
            open_record = rec;
            nest        = '0;
            attr_depth  = '0;
            first_seen  = 1'b0;
            second_seen = 1'b0;
        end
        case (kind)
            CMD_START_TAG:
            begin
                if (nest != DEPTH_TOP)
                    nest = nest + 1'b1;
                tag_record   = rec;
                tag_position = pos;
                tag_held     = 1'b1;
                check_attribute();
            end
            CMD_END_TAG:
            begin
                if (nest == attr_depth)
                    attr_depth = '0;
                if (nest != DEPTH_BOTTOM)
                    nest = nest - 1'b1;
                if (nest == '0)
                begin
                    first_seen  = 1'b0;
                    second_seen = 1'b0;
                end
            end
            CMD_ATTRIBUTE:
            begin
                attr_record   = rec;
                attr_position = pos;
                attr_held     = 1'b1;
                check_attribute();
            end
            default:
            begin
                if (nest != '0 && attr_depth != '0)
                begin
                    if (!split_on)
                    begin
                        first_seen  = 1'b1;
                        second_seen = 1'b1;
                    end
                    else if (kind == CMD_MIDDLE_TWO)
                        second_seen = 1'b1;
                    else
                        first_seen = 1'b1;
                    fired = first_seen && second_seen;
                end
            end
        endcase
    endtask

    always @(posedge clk or negedge rst_n)
    begin : watch
        hit_t got;
        hit_t want;
        logic fired;
        if (!rst_n)
        begin
            attr_on        = 1'b0;
            split_on       = 1'b0;
            record_open    = 1'b0;
            open_record    = '0;
            tag_record     = '0;
            tag_position   = '0;
            tag_held       = 1'b0;
            attr_record    = '0;
            attr_position  = '0;
            attr_held      = 1'b0;
            nest           = '0;
            attr_depth     = '0;
            first_seen     = 1'b0;
            second_seen    = 1'b0;
            leftovers_done = 1'b0;
            expected_hits.delete();
            pending        = 0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                if (cfg_index == REG_ATTRIBUTES_PRESENT)
                    attr_on = cfg_data;
                else if (cfg_index == REG_SPLIT_MIDDLE)
                    split_on = cfg_data;
            end
            if (m_tvalid && m_tready)
            begin
                got.hit_record   = m_tdata[RECORD_BITS-1:0];
                got.hit_position = m_tdata[RECORD_BITS+POSITION_BITS-1:RECORD_BITS];
                hits_seen++;
                if (expected_hits.size() == 0)
                    report_mismatch($sformatf("hit record %0h position %0h was not predicted",
                                              got.hit_record, got.hit_position));
                else
                begin
                    want = expected_hits.pop_front();
                    if (got.hit_record !== want.hit_record)
                        report_mismatch($sformatf("hit_record %0h, predicted %0h",
                                                  got.hit_record, want.hit_record));
                    if (got.hit_position !== want.hit_position)
                        report_mismatch($sformatf("hit_position %0h, predicted %0h",
                                                  got.hit_position, want.hit_position));
                end
            end
            if (s_tvalid && s_tready)
            begin
                keys_seen++;
                want.hit_record   = s_tdata[RECORD_BITS-1:0];
                want.hit_position = s_tdata[RECORD_BITS+POSITION_BITS-1:RECORD_BITS];
                track_key(s_tuser, want.hit_record, want.hit_position, fired);
                if (fired)
                    expected_hits.push_back(want);
            end
            if (run_done && !leftovers_done)
            begin
                leftovers_done = 1'b1;
                if (expected_hits.size() != 0)
                    report_mismatch($sformatf("%0d predicted hits never came out",
                                              expected_hits.size()));
                expected_hits.delete();
            end
            pending = expected_hits.size();
        end
    end

endmodule

// File: test/structural_containment_filter_tb.sv
// Testbench top for the structural containment filter: stimulus, stalls and verdict.
module structural_containment_filter_tb;
    import scf_pkg::*;

    localparam int RECORD_BITS   = 32;
    localparam int POSITION_BITS = 32;
    localparam int DEPTH_BITS    = 8;
    localparam int DATA_BITS     = ((RECORD_BITS + POSITION_BITS + 7) / 8) * 8;

    // The slowest correct run stays well below this even with every key waiting out
    // the longest source gap and sink stall, so hitting it means the filter hung.
    localparam int CYCLE_LIMIT   = 600000;
    // Idle time after the last predicted hit, for keys in flight that produce no hit.
    localparam int DRAIN_CYCLES  = 8;
    // Length of the one long sink stall that backs the filter up.
    localparam int HOLD_CYCLES   = 200;
    localparam int PHASE_KEYS    = 230;
    localparam int RANDOM_PHASES = 6;
    // Kinds above the last defined one are dropped by the filter.
    localparam logic [CMD_BITS-1:0] KIND_UNUSED_FIRST = 3'd5;
    localparam logic [CMD_BITS-1:0] KIND_UNUSED_LAST  = 3'd7;

    logic                      clk;
    logic                      rst_n;
    logic                      s_tvalid;
    logic                      s_tready;
    // tdata: record_id, then position.
    logic [DATA_BITS-1:0]      s_tdata;
    // tuser: command.
    logic [CMD_BITS-1:0]       s_tuser;
    logic                      m_tvalid;
    logic                      m_tready;
    // tdata: hit_record, then hit_position.
    logic [DATA_BITS-1:0]      m_tdata;
    logic                      cfg_valid;
    logic                      cfg_ready;
    logic [CFG_INDEX_BITS-1:0] cfg_index;
    logic                      cfg_data;
    logic                      run_done;

    int mismatches;
    int pending;
    int keys_seen;
    int hits_seen;

    // Generator state: the record the next element goes into and a running position.
    logic [RECORD_BITS-1:0]    cur_rec;
    logic [POSITION_BITS-1:0]  pos_cursor;
    int                        keys_sent;
    int                        settings_used;
    int                        cycles;
    logic                      steady_source;
    logic                      steady_sink;
    logic                      hold_pending;

    structural_containment_filter #(
        .RECORD_BITS   (RECORD_BITS),
        .POSITION_BITS (POSITION_BITS),
        .DEPTH_BITS    (DEPTH_BITS)
    ) i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // The checker sees every handshake on all three channels and owns the prediction;
    // this module only feeds the filter and reads back the counts.
    structural_containment_filter_checker #(
        .RECORD_BITS   (RECORD_BITS),
        .POSITION_BITS (POSITION_BITS),
        .DEPTH_BITS    (DEPTH_BITS),
        .DATA_BITS     (DATA_BITS)
    ) i_checker (
        .clk        (clk),
        .rst_n      (rst_n),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tuser    (s_tuser),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .run_done   (run_done),
        .mismatches (mismatches),
        .pending    (pending),
        .keys_seen  (keys_seen),
        .hits_seen  (hits_seen)
    );

    initial
    begin
        clk = 1'b0;
    end

    always #6 clk = ~clk;

    // Watchdog: a hung handshake ends the run as a failure.
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles == CYCLE_LIMIT)
        begin
            $display("Timed out after %0d cycles with %0d hits still predicted", cycles, pending);
            $display("Mismatches found");
            $finish;
        end
    end

    // Gap lengths for both sides: mostly none, otherwise short, now and then a long one.
    function automatic int pick_gap();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 55)
            return 0;
        if (roll < 90)
            return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    // Positions mostly climb in small steps, with an occasional jump anywhere in the field.
    function automatic logic [POSITION_BITS-1:0] next_position();
        if ($urandom_range(0, 9) == 0)
            pos_cursor = POSITION_BITS'($urandom);
        else
            pos_cursor = POSITION_BITS'(pos_cursor + $urandom_range(1, 16));
        return pos_cursor;
    endfunction

    // Offers one key item and returns on the falling edge after it was taken. tvalid stays
    // high on return so a back-to-back item goes out without a bubble.
    task automatic send_key(input logic [CMD_BITS-1:0]      kind,
                            input logic [RECORD_BITS-1:0]   rec,
                            input logic [POSITION_BITS-1:0] pos);
        int gap;
        gap = steady_source ? 0 : pick_gap();
        if (gap > 0)
        begin
            s_tvalid = 1'b0;
            repeat (gap) @(negedge clk);
        end
        s_tvalid = 1'b1;
        s_tuser  = kind;
        s_tdata  = DATA_BITS'({pos, rec});
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        @(negedge clk);
        if (kind <= CMD_MIDDLE_TWO)
            keys_sent++;
    endtask

    // Configuration may only change while nothing is in flight: wait for every predicted
    // hit, then let the pipeline empty out of keys that produce none.
    task automatic wait_idle();
        s_tvalid = 1'b0;
        while (pending != 0)
            @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);
    endtask

    task automatic write_reg(input logic [CFG_INDEX_BITS-1:0] idx, input logic value);
        cfg_valid = 1'b1;
        cfg_index = idx;
        cfg_data  = value;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        @(negedge clk);
        cfg_valid = 1'b0;
    endtask

    task automatic set_config(input logic attr_on, input logic split_on);
        wait_idle();
        write_reg(REG_ATTRIBUTES_PRESENT, attr_on);
        write_reg(REG_SPLIT_MIDDLE, split_on);
        settings_used++;
    endtask

    // One element of the current record: a start tag, usually an attribute key that
    // matches it (before or after the tag), sometimes one that does not, a run of middle
    // keys with maybe a child element in between, and usually a closing end tag.
    task automatic gen_element(input int middles);
        logic [POSITION_BITS-1:0] tag_pos;
        int                       attr_mode;
        tag_pos   = next_position();
        attr_mode = $urandom_range(0, 9);
        if (attr_mode < 2)
            send_key(CMD_ATTRIBUTE, cur_rec, tag_pos);
        send_key(CMD_START_TAG, cur_rec, tag_pos);
        if (attr_mode >= 2 && attr_mode < 7)
            send_key(CMD_ATTRIBUTE, cur_rec, tag_pos);
        else if (attr_mode == 7)
            send_key(CMD_ATTRIBUTE, cur_rec, next_position());
        for (int i = 0; i < middles; i++)
        begin
            if (i == middles / 2 && $urandom_range(0, 3) == 0)
            begin
                tag_pos = next_position();
                send_key(CMD_START_TAG, cur_rec, tag_pos);
                if ($urandom_range(0, 1) == 1)
                    send_key(CMD_ATTRIBUTE, cur_rec, tag_pos);
                send_key(CMD_BITS'($urandom_range(CMD_MIDDLE_ONE, CMD_MIDDLE_TWO)), cur_rec,
                         next_position());
                send_key(CMD_END_TAG, cur_rec, next_position());
            end
            send_key(CMD_BITS'($urandom_range(CMD_MIDDLE_ONE, CMD_MIDDLE_TWO)), cur_rec,
                     next_position());
        end
        if ($urandom_range(0, 7) != 0)
            send_key(CMD_END_TAG, cur_rec, next_position());
    endtask

    // Mostly well-formed elements; sometimes the record moves on (forward, back or
    // anywhere), and the rest is noise of any kind, including the ignored ones.
    task automatic gen_sequence();
        int pick;
        pick = $urandom_range(0, 99);
        if (pick < 15)
        begin
            case ($urandom_range(0, 9))
                0, 1:    cur_rec = RECORD_BITS'($urandom);
                2:       cur_rec = RECORD_BITS'(cur_rec - $urandom_range(1, 100));
                default: cur_rec = RECORD_BITS'(cur_rec + $urandom_range(1, 3));
            endcase
            pos_cursor = ($urandom_range(0, 3) == 0) ? POSITION_BITS'($urandom) : '0;
        end
        if (pick < 82)
            gen_element($urandom_range(0, 6));
        else
            repeat ($urandom_range(1, 4))
                send_key(CMD_BITS'($urandom_range(CMD_START_TAG, KIND_UNUSED_LAST)),
                         ($urandom_range(0, 3) == 0) ? RECORD_BITS'($urandom) : cur_rec,
                         POSITION_BITS'($urandom));
    endtask

    // Sink side. It stalls in random bursts unless told to run flat out, and once takes
    // a long hold-off, counted here, during which the source keeps offering keys.
    initial
    begin : sink_side
        int   stall_left;
        int   held;
        logic hold_taken;
        stall_left = 0;
        hold_taken = 1'b0;
        m_tready   = 1'b1;
        wait (rst_n);
        forever
        begin
            @(negedge clk);
            if (hold_pending && !hold_taken)
            begin
                m_tready = 1'b0;
                held     = 0;
                while (held < HOLD_CYCLES)
                begin
                    @(negedge clk);
                    held++;
                end
                hold_taken = 1'b1;
                m_tready   = 1'b1;
            end
            else if (steady_sink)
                m_tready = 1'b1;
            else if (stall_left > 0)
            begin
                m_tready = 1'b0;
                stall_left--;
            end
            else
            begin
                m_tready = 1'b1;
                if ($urandom_range(0, 99) < 30)
                    stall_left = pick_gap();
            end
        end
    end

    initial
    begin : stimulus
        logic [POSITION_BITS-1:0] tag_pos;
        int                       phase_goal;
        rst_n         = 1'b0;
        s_tvalid      = 1'b0;
        s_tdata       = '0;
        s_tuser       = '0;
        cfg_valid     = 1'b0;
        cfg_index     = '0;
        cfg_data      = 1'b0;
        run_done      = 1'b0;
        cur_rec       = '0;
        pos_cursor    = '0;
        keys_sent     = 0;
        settings_used = 1;
        steady_source = 1'b0;
        steady_sink   = 1'b0;
        hold_pending  = 1'b0;
        repeat (5) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // Directed part, first with the registers as reset left them: attributes off,
        // so every element matches, and either middle kind sets both flags.
        // The very first key opens record zero even though that equals the reset id;
        // with nothing open the middle key is dropped.
        send_key(CMD_MIDDLE_ONE, '0, '0);
        // An unused kind with an all-ones record must not look like a record change.
        send_key(KIND_UNUSED_FIRST, '1, '1);
        send_key(CMD_START_TAG, '0, 1);
        send_key(CMD_MIDDLE_ONE, '0, 2);
        send_key(CMD_MIDDLE_TWO, '0, 3);
        // Closing back to depth zero clears the flags, so the next middle key is dropped.
        send_key(CMD_END_TAG, '0, 4);
        send_key(CMD_MIDDLE_ONE, '0, 5);
        // Two surplus end tags: depth goes negative, and the second one lands on the
        // always-match level and clears it.
        send_key(CMD_END_TAG, '0, 6);
        send_key(CMD_END_TAG, '0, 7);
        // With attributes off an attribute key just restores the always-match level,
        // and a middle key at negative depth still hits.
        send_key(CMD_ATTRIBUTE, '0, 8);
        send_key(CMD_START_TAG, '0, 9);
        send_key(CMD_MIDDLE_TWO, '0, 10);
        send_key(KIND_UNUSED_LAST, '0, '0);
        // Largest record and position values.
        send_key(CMD_START_TAG, '1, '0);
        send_key(CMD_MIDDLE_TWO, '1, '1);
        // Record id going backward is a new record as well.
        send_key(CMD_MIDDLE_ONE, 1, 0);

        // Attributes on and split middle flags: a match needs equal keys, a hit needs both.
        set_config(1'b1, 1'b1);
        send_key(CMD_START_TAG, 2, 10);
        send_key(CMD_ATTRIBUTE, 2, 10);
        send_key(CMD_MIDDLE_ONE, 2, 11);
        send_key(CMD_MIDDLE_TWO, 2, 12);
        send_key(CMD_MIDDLE_ONE, 2, 13);
        // The end tag at the attribute level clears the match.
        send_key(CMD_END_TAG, 2, 14);
        // Attribute key ahead of its start tag still matches once the tag arrives.
        send_key(CMD_ATTRIBUTE, 2, 20);
        send_key(CMD_START_TAG, 2, 20);
        send_key(CMD_MIDDLE_TWO, 2, 21);
        send_key(CMD_MIDDLE_ONE, 2, 22);
        cur_rec    = 2;
        pos_cursor = 22;

        // Random part, one register setting per phase; the four corner settings come
        // first, then random ones.
        for (int phase = 0; phase < RANDOM_PHASES; phase++)
        begin
            case (phase)
                0:       set_config(1'b0, 1'b0);
                1:       set_config(1'b1, 1'b0);
                2:       set_config(1'b0, 1'b1);
                3:       set_config(1'b1, 1'b1);
                default: set_config(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
            endcase
            // Phase two runs both sides without any idling; elsewhere each side does so one time in four.
            steady_source = (phase == 2) || ($urandom_range(0, 3) == 0);
            steady_sink   = (phase == 2) || ($urandom_range(0, 3) == 0);

            if (phase == 0)
            begin
                // Long sink stall under a stream of hitting middle keys, so the output
                // register and the input stage both fill and s_tready drops.
                hold_pending = 1'b1;
                gen_element(40);
            end

            if (phase == 1)
            begin
                // Nest past the top of the depth range with a matched attribute on the
                // way up, then close far more tags than were opened so the depth pins
                // at the bottom of its range. Middle keys sprinkled along the way.
                cur_rec    = RECORD_BITS'(cur_rec + 1);
                pos_cursor = '0;
                for (int d = 0; d < 130; d++)
                begin
                    tag_pos = next_position();
                    send_key(CMD_START_TAG, cur_rec, tag_pos);
                    if (d == 5)
                        send_key(CMD_ATTRIBUTE, cur_rec, tag_pos);
                end
                send_key(CMD_MIDDLE_ONE, cur_rec, next_position());
                send_key(CMD_MIDDLE_TWO, cur_rec, next_position());
                for (int d = 0; d < 260; d++)
                begin
                    send_key(CMD_END_TAG, cur_rec, next_position());
                    if (d % 64 == 0)
                        send_key(CMD_BITS'($urandom_range(CMD_MIDDLE_ONE, CMD_MIDDLE_TWO)),
                                 cur_rec, next_position());
                end
            end

            phase_goal = keys_sent + PHASE_KEYS;
            while (keys_sent < phase_goal)
                gen_sequence();
        end

        // Drain: every predicted hit has to come out, then the checker flags leftovers.
        wait_idle();
        run_done = 1'b1;
        @(negedge clk);
        @(negedge clk);

        $display("Sent %0d keys under %0d register settings; the filter returned %0d hits.",
                 keys_seen, settings_used, hits_seen);
        $display("Included: depth saturation both ways, record changes, a %0d-cycle sink stall.",
                 HOLD_CYCLES);
        if (mismatches == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule

// File: structural_containment_filter.f
rtl/core/scf_pkg.sv
rtl/core/scf_tracker.sv
rtl/core/structural_containment_filter.sv
test/structural_containment_filter_checker.sv
test/structural_containment_filter_tb.sv
